// ===== design/owrb_pkg.sv =====
// Overwriting ring buffer: shared types, operation codes and parameter defaults.
// No dependencies; used by owrb_outq, owrb_ctrl and the top level.
`timescale 1ns / 1ps

package owrb_pkg;

    localparam int DEPTH_DEF        = 1024;
    localparam int RECORD_WIDTH_DEF = 64;
    localparam int MAX_BURST_DEF    = 64;

    localparam int DATA_W  = 64;
    localparam int COUNT_W = 7;
    localparam int KIND_W  = 2;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } owrb_state_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic empty;
    } owrb_rd_req_t;

    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } owrb_q_stat_t;

endpackage

// ===== design/owrb_mem.sv =====
// Record store: single-port-write, single-port-read synchronous memory.
// Read data registered. Depends on nothing.
`timescale 1ns / 1ps

module owrb_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/owrb_outq.sv =====
// Two-entry output queue that decouples memory reads from result backpressure.
// Depends on owrb_pkg for the status struct.
`timescale 1ns / 1ps

module owrb_outq #(
    parameter int WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rstn,
    input  logic                  push,
    input  logic [WIDTH-1:0]      push_data,
    input  logic                  push_last,
    input  logic                  push_empty,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [WIDTH-1:0]      out_data,
    output logic                  out_last,
    output logic                  out_empty,
    output owrb_pkg::owrb_q_stat_t stat
);

    logic [WIDTH+1:0] slot_reg [2];
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic             pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign {out_data, out_last, out_empty} = slot_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.pop   = pop;

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= {push_data, push_last, push_empty};
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

// ===== design/owrb_ctrl.sv =====
// Pointer and read sequencer: head/tail pointers, write/clear handling and
// read issue under output-queue credit. Depends on owrb_pkg.
`timescale 1ns / 1ps

module owrb_ctrl #(
    parameter int DEPTH        = 1024,
    parameter int MAX_BURST    = 64,
    parameter int PTR_W        = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        rstn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [owrb_pkg::KIND_W-1:0] kind,
    input  logic [owrb_pkg::COUNT_W-1:0] want,
    output logic                        mem_we,
    output logic [PTR_W-1:0]            mem_waddr,
    output logic                        mem_re,
    output logic [PTR_W-1:0]            mem_raddr,
    output owrb_pkg::owrb_rd_req_t      rd_req,
    input  owrb_pkg::owrb_q_stat_t      q_stat
);

    localparam int CNT_W = $clog2(MAX_BURST + 1);
    localparam int CMP_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

    owrb_pkg::owrb_state_t  state_reg, state_next;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [PTR_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       remaining_reg, remaining_next;
    logic                   empty_reg, empty_next;
    owrb_pkg::owrb_rd_req_t rd_req_reg, rd_req_next;

    logic [PTR_W-1:0] head_adv;
    logic [PTR_W-1:0] tail_adv;
    logic [PTR_W:0]   wrap_sum;
    logic [PTR_W-1:0] avail;
    logic [CNT_W-1:0] want_c;
    logic [CNT_W-1:0] n;
    logic [2:0]       occ;
    logic             credit;
    logic             is_last;

    assign head_adv = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_adv = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign wrap_sum = (PTR_W + 1)'(DEPTH) - {1'b0, tail_reg} + {1'b0, head_reg};
    assign avail    = (head_reg >= tail_reg) ? head_reg - tail_reg : wrap_sum[PTR_W-1:0];
    assign want_c   = (want > owrb_pkg::COUNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST)
                                                             : want[CNT_W-1:0];
    assign n        = (CMP_W'(want_c) < CMP_W'(avail)) ? want_c : CNT_W'(avail);

    assign occ    = {1'b0, q_stat.count} + {2'b00, rd_req_reg.valid} - {2'b00, q_stat.pop};
    assign credit = (occ < 3'd2);

    assign mem_waddr = head_reg;
    assign mem_raddr = tail_reg;
    assign rd_req    = rd_req_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg     <= owrb_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            remaining_reg <= '0;
            empty_reg     <= 1'b0;
            rd_req_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            remaining_reg <= remaining_next;
            empty_reg     <= empty_next;
            rd_req_reg    <= rd_req_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        remaining_next = remaining_reg;
        empty_next     = empty_reg;
        rd_req_next    = '0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        is_last        = empty_reg || (remaining_reg == CNT_W'(1));
        in_ready       = (state_reg == owrb_pkg::ST_IDLE);
        case (state_reg)
            owrb_pkg::ST_IDLE: begin
                if (in_valid) begin
                    case (kind)
                        owrb_pkg::KIND_WRITE: begin
                            mem_we    = 1'b1;
                            head_next = head_adv;
                            if (head_adv == tail_reg) begin
                                tail_next = tail_adv;
                            end
                        end
                        owrb_pkg::KIND_READ: begin
                            if (want_c != '0) begin
                                remaining_next = n;
                                empty_next     = (avail == '0);
                                state_next     = owrb_pkg::ST_READ;
                            end
                        end
                        owrb_pkg::KIND_CLEAR: begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            owrb_pkg::ST_READ: begin
                if (credit) begin
                    rd_req_next.valid = 1'b1;
                    rd_req_next.last  = is_last;
                    rd_req_next.empty = empty_reg;
                    if (!empty_reg) begin
                        mem_re         = 1'b1;
                        tail_next      = tail_adv;
                        remaining_next = remaining_reg - 1'b1;
                    end
                    if (is_last) begin
                        state_next = owrb_pkg::ST_IDLE;
                        if (!empty_reg && (tail_adv == head_reg)) begin
                            head_next = '0;
                            tail_next = '0;
                        end
                    end
                end
            end
            default: begin
                state_next = owrb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/overwriting_ring_buffer.sv =====
// Top level of the overwriting ring buffer: stream ports, record store,
// pointer sequencer and output queue. Depends on owrb_pkg, owrb_mem,
// owrb_ctrl and owrb_outq.
//
//  port group | dir | tdata (low bit up)                      | tuser     | tlast
//  s_         | in  | write_data[63:0], read_count[70:64], pad| kind[1:0] | -
//  m_         | out | read_data[63:0]                         | empty_res | last
//
// A write or clear completes when accepted; writes are taken back to back while no read is in progress.
// A read first takes the request, then issues one record per cycle, while the
// output queue has space, through the single read port of the record store.
// Each result passes the read register of the record store and then a slot of
// the two-entry queue, where it can stall; the read sequencer waits on queue space.
// Reset clears both pointers; the store needs no clearing pass.
`timescale 1ns / 1ps

module overwriting_ring_buffer #(
    parameter int DEPTH        = owrb_pkg::DEPTH_DEF,
    parameter int RECORD_WIDTH = owrb_pkg::RECORD_WIDTH_DEF,
    parameter int MAX_BURST    = owrb_pkg::MAX_BURST_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // write_data[63:0], read_count[70:64], zero
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // read_data[63:0]
    output logic        m_tlast,
    output logic        m_tuser    // empty_res
);

    localparam int PTR_W = $clog2(DEPTH);

    logic                    mem_we;
    logic [PTR_W-1:0]        mem_waddr;
    logic                    mem_re;
    logic [PTR_W-1:0]        mem_raddr;
    logic [RECORD_WIDTH-1:0] mem_rdata;
    logic [RECORD_WIDTH-1:0] push_data;
    logic [RECORD_WIDTH-1:0] q_data;
    owrb_pkg::owrb_rd_req_t  rd_req;
    owrb_pkg::owrb_q_stat_t  q_stat;

    owrb_ctrl #(
        .DEPTH        (DEPTH),
        .MAX_BURST    (MAX_BURST),
        .PTR_W        (PTR_W)
    ) u_ctrl (
        .clk       (aclk),
        .rstn      (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .kind      (s_tuser),
        .want      (s_tdata[70:64]),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .rd_req    (rd_req),
        .q_stat    (q_stat)
    );

    owrb_mem #(
        .DEPTH  (DEPTH),
        .WIDTH  (RECORD_WIDTH),
        .ADDR_W (PTR_W)
    ) u_mem (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (s_tdata[RECORD_WIDTH-1:0]),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign push_data = rd_req.empty ? '0 : mem_rdata;

    owrb_outq #(
        .WIDTH (RECORD_WIDTH)
    ) u_outq (
        .clk        (aclk),
        .rstn       (aresetn),
        .push       (rd_req.valid),
        .push_data  (push_data),
        .push_last  (rd_req.last),
        .push_empty (rd_req.empty),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (q_data),
        .out_last   (m_tlast),
        .out_empty  (m_tuser),
        .stat       (q_stat)
    );

    assign m_tdata = 64'(q_data);

endmodule

// ===== design/owrb_chk.sv =====
// Port-level checker for the overwriting ring buffer, bound to the top level.
// Depends on overwriting_ring_buffer.
`timescale 1ns / 1ps

module owrb_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("empty result without last");

    a_empty_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 64'd0))
        else $error("empty result carries data");

    a_ready_holds_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && !s_tvalid) |=> s_tready)
        else $error("input ready dropped with no transfer");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                     && $stable(m_tuser)))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind overwriting_ring_buffer owrb_chk u_owrb_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
